// File: rtl/gacl_pkg.sv
// Shared constants, codes, types and word functions of the guarded attempt counter.
package gacl_pkg;

  localparam int LOG_DEPTH_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int CNT_W         = 6;

  localparam logic [31:0] PAIR_LO = 32'h5555_5555;
  localparam logic [31:0] PAIR_2  = 32'h3333_3333;
  localparam logic [31:0] NIBBLE  = 32'h0F0F_0F0F;

  localparam logic [CNT_W-1:0] MAX_TRIES_RST = 6'd15;

  localparam logic [1:0] REQ_INIT     = 2'd0;
  localparam logic [1:0] REQ_INCREASE = 2'd1;
  localparam logic [1:0] REQ_GET      = 2'd2;
  localparam logic [1:0] REQ_RESET    = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FAULT  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL,
    S_READ,
    S_CHECK,
    S_DONE
  } fsm_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] fail_count;
    logic             over_limit;
  } result_t;

  function automatic logic [31:0] gmask_of(input logic [31:0] k);
    return ((k & PAIR_LO) << 1) | (~k & PAIR_LO);
  endfunction

  function automatic logic [31:0] guard_of(input logic [31:0] k);
    return (((k & PAIR_LO) << 1) & k) | ((~k & PAIR_LO) & (k >> 1));
  endfunction

  function automatic logic [31:0] unused_of(input logic [31:0] k);
    return guard_of(k) | ~gmask_of(k);
  endfunction

  // Shift every set data pair down by one pair, clearing one more data bit.
  function automatic logic [31:0] inc_word(input logic [31:0] e, input logic [31:0] gm,
                                           input logic [31:0] g);
    logic [31:0] w;
    w = e & ~gm;
    w = ((w >> 1) | w) & PAIR_LO;
    w = (w >> 2) | (w >> 1);
    return (w & ~gm) | g;
  endfunction

  // Data bits duplicated across each pair must read as 0*1*.
  function automatic logic form_bad(input logic [31:0] e, input logic [31:0] gm);
    logic [31:0] w;
    w = e & ~gm;
    w = ((w >> 1) | w) & PAIR_LO;
    w = w | (w << 1);
    return (w & (w + 32'd1)) != 32'd0;
  endfunction

  function automatic logic [CNT_W-1:0] popcount32(input logic [31:0] v);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [7:0]  t;
    a = v - ((v >> 1) & PAIR_LO);
    b = (a & PAIR_2) + ((a >> 2) & PAIR_2);
    c = (b + (b >> 4)) & NIBBLE;
    t = c[7:0] + c[15:8] + c[23:16] + c[31:24];
    return t[CNT_W-1:0];
  endfunction

endpackage

// File: rtl/gacl_if.sv
// Request and response channel interfaces of the guarded attempt counter.
interface gacl_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] new_guard_key;

  modport source (output valid, output req_type, output new_guard_key, input ready);
  modport sink   (input valid, input req_type, input new_guard_key, output ready);
endinterface

interface gacl_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] fail_count;
  logic       over_limit;

  modport source (output valid, output status, output fail_count, output over_limit,
                  input ready);
  modport sink   (input valid, input status, input fail_count, input over_limit,
                  output ready);
endinterface

// File: rtl/gacl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gacl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gacl_ctrl.sv
// Request sequencer: walks the logs word by word, checks, updates and forms the result.
module gacl_ctrl import gacl_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF,
  localparam int AW       = $clog2(LOG_DEPTH)
) (
  input  logic              clk,
  input  logic              rst,
  gacl_req_if.sink          req,
  gacl_rsp_if.source        rsp,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata,
  output logic [AW-1:0]     raddr,
  output logic              e_we,
  output logic [WORD_W-1:0] e_wdata,
  output logic              s_we,
  output logic [WORD_W-1:0] s_wdata,
  output logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] e_rdata,
  input  logic [WORD_W-1:0] s_rdata
);

  fsm_t             state, state_next;
  logic [1:0]       op;
  logic [31:0]      nk;
  logic [31:0]      key_word;
  logic             logs_valid;
  logic [AW-1:0]    idx;
  logic             found;
  logic             pend0;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] pop_prev;
  logic [CNT_W-1:0] max_tries;
  result_t          res;
  result_t          out_q;
  logic             out_valid;

  logic [31:0]      gm, g, u, fill_word;
  logic             is_last;
  logic             bad_e, bad_s, bad_sub, newfound, get_bad;
  logic [CNT_W-1:0] pop_cur;
  logic [CNT_W:0]   pair_sum;
  logic [CNT_W-1:0] cnt_next;
  logic             chk_done, chk_fill;
  logic [1:0]       chk_status;
  logic             accept, out_load;

  assign gm        = gmask_of(key_word);
  assign g         = guard_of(key_word);
  assign u         = g | ~gm;
  assign fill_word = unused_of(nk);
  assign is_last   = idx == AW'(LOG_DEPTH - 1);

  assign bad_e    = (e_rdata & gm) != g;
  assign bad_s    = (s_rdata & gm) != g;
  assign bad_sub  = (e_rdata & s_rdata) != e_rdata;
  assign newfound = !found && (e_rdata != g);
  assign get_bad  = bad_e || bad_s || bad_sub || (found && (e_rdata != u)) ||
                    (newfound && form_bad(e_rdata, gm));
  assign pop_cur  = popcount32(s_rdata ^ e_rdata);
  assign pair_sum = {1'b0, pop_prev} + {1'b0, pop_cur};
  assign cnt_next = ((newfound && idx != '0) || pend0) ? pair_sum[CNT_W-1:0] : cnt;

  assign accept   = req.valid && req.ready;
  assign out_load = (state == S_DONE) && (!out_valid || rsp.ready);

  // Decide per checked word whether the request ends here or moves on to a refill.
  always_comb begin
    chk_done   = 1'b0;
    chk_fill   = 1'b0;
    chk_status = ST_OK;
    case (op)
      REQ_INCREASE: begin
        if (bad_e) begin
          chk_done   = 1'b1;
          chk_status = ST_FAULT;
        end else if (e_rdata != g) begin
          chk_done = 1'b1;
        end else if (is_last) begin
          chk_done   = 1'b1;
          chk_status = ST_FAULT;
        end
      end
      REQ_GET: begin
        if (get_bad) begin
          chk_done   = 1'b1;
          chk_status = ST_FAULT;
        end else if (is_last) begin
          chk_done   = 1'b1;
          chk_status = (found || newfound) ? ST_OK : ST_FAULT;
        end
      end
      REQ_RESET: begin
        if (e_rdata == u) begin
          chk_done = 1'b1;
        end else if (is_last) begin
          chk_fill = 1'b1;
        end
      end
      default: begin
        chk_done = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_INIT) begin
            state_next = S_FILL;
          end else if (!logs_valid) begin
            state_next = S_DONE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_FILL: begin
        if (is_last) state_next = S_DONE;
      end
      S_READ: state_next = S_CHECK;
      S_CHECK: begin
        if (chk_done) begin
          state_next = S_DONE;
        end else if (chk_fill) begin
          state_next = S_FILL;
        end else begin
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (out_load) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req.ready = state == S_IDLE;
    raddr     = idx;
    waddr     = idx;
    e_we      = 1'b0;
    s_we      = 1'b0;
    e_wdata   = inc_word(e_rdata, gm, g);
    s_wdata   = e_rdata;
    case (state)
      S_FILL: begin
        e_we    = 1'b1;
        s_we    = 1'b1;
        e_wdata = fill_word;
        s_wdata = fill_word;
      end
      S_CHECK: begin
        e_we = (op == REQ_INCREASE) && !bad_e && (e_rdata != g);
        s_we = (op == REQ_RESET) && (e_rdata != u) && (s_rdata != g);
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.status     = out_q.status;
  assign rsp.fail_count = out_q.fail_count;
  assign rsp.over_limit = out_q.over_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      key_word   <= '0;
      logs_valid <= 1'b0;
      max_tries  <= MAX_TRIES_RST;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) max_tries <= cfg_wdata;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      if (state == S_FILL && is_last) begin
        key_word   <= nk;
        logs_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_q <= res;
    case (state)
      S_IDLE: begin
        op       <= req.req_type;
        nk       <= req.new_guard_key;
        idx      <= '0;
        found    <= 1'b0;
        pend0    <= 1'b0;
        cnt      <= '0;
        pop_prev <= '0;
        res      <= '{status: ST_ABSENT, fail_count: '0, over_limit: 1'b0};
      end
      S_FILL: begin
        idx <= idx + AW'(1);
        res <= '{status: ST_OK, fail_count: '0, over_limit: 1'b0};
      end
      S_CHECK: begin
        found    <= found || newfound;
        pend0    <= newfound && idx == '0;
        cnt      <= cnt_next;
        pop_prev <= pop_cur;
        idx      <= chk_fill ? '0 : idx + AW'(1);
        if (op == REQ_GET && chk_status == ST_OK) begin
          res <= '{status: ST_OK, fail_count: cnt_next,
                   over_limit: cnt_next > max_tries};
        end else begin
          res <= '{status: chk_status, fail_count: '0, over_limit: 1'b0};
        end
      end
      default: begin
      end
    endcase
  end

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_IDLE) |-> !(e_we || s_we))
    else $error("log write outside fill or check");

  a_fill_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL && is_last) |=> logs_valid)
    else $error("logs not valid after fill");

  a_absent_only_when_empty: assert property (@(posedge clk) disable iff (rst)
    (out_load && res.status == ST_ABSENT) |-> !logs_valid)
    else $error("absent status with logs present");

  a_count_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_OK) |-> (rsp.fail_count == '0 && !rsp.over_limit))
    else $error("count reported on a failed request");

endmodule

// File: rtl/guarded_attempt_counter_log.sv
// Top level of the guarded failed-attempt counter: sequencer plus entry and success logs.
// Each request is handled alone, one log word at a time through two single-port-read
// RAMs: a read state and then a check/write-back state per word. Init fills every log
// word; increase, get and reset scan the logs up to the last word, and a reset that finds
// the log full adds a refill of every word; accept and result hand-off come on top. A
// finished result sits in an output register, so the next request is taken while it
// waits. The logs need no clearing after reset: they are read only once an init has filled
// them. The user writes max_tries through cfg_we/cfg_wdata only while the block idles; the block does not enforce it.
module guarded_attempt_counter_log import gacl_pkg::*; #(
  parameter int LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  gacl_req_if.sink         req,
  gacl_rsp_if.source       rsp,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(LOG_DEPTH);

  logic [AW-1:0]     raddr, waddr;
  logic              e_we, s_we;
  logic [WORD_W-1:0] e_wdata, s_wdata, e_rdata, s_rdata;

  gacl_ctrl #(.LOG_DEPTH(LOG_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .raddr     (raddr),
    .e_we      (e_we),
    .e_wdata   (e_wdata),
    .s_we      (s_we),
    .s_wdata   (s_wdata),
    .waddr     (waddr),
    .e_rdata   (e_rdata),
    .s_rdata   (s_rdata)
  );

  gacl_ram #(.WIDTH(WORD_W), .DEPTH(LOG_DEPTH)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (waddr),
    .wdata (e_wdata),
    .raddr (raddr),
    .rdata (e_rdata)
  );

  gacl_ram #(.WIDTH(WORD_W), .DEPTH(LOG_DEPTH)) u_success_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (waddr),
    .wdata (s_wdata),
    .raddr (raddr),
    .rdata (s_rdata)
  );

endmodule
